@@ src/rre_pkg.sv @@
// ----------------------------------------------------------------------------
// rre_pkg
// Shared widths, reset values, register indexes and the update record for
// the RTT / RTO estimator.
// ----------------------------------------------------------------------------
package rre_pkg;

  localparam int RTT_W       = 20;
  localparam int CNT_W       = 32;
  localparam int BKT_W       = 3;
  localparam int NUM_BUCKETS = 7;
  localparam int NUM_LIMITS  = NUM_BUCKETS - 1;
  localparam int CFG_IDX_W   = 1;
  localparam int VAR4_W      = RTT_W + 2;
  localparam int SUM_W       = RTT_W + 3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RTO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RTO = 1'b1;

  localparam logic [RTT_W-1:0]  MIN_RTO_RESET = RTT_W'(200);
  localparam logic [RTT_W-1:0]  MAX_RTO_RESET = RTT_W'(60000);
  localparam logic [VAR4_W-1:0] RTO_FLOOR     = VAR4_W'(10);

  localparam logic [RTT_W-1:0] BKT_LIMIT [NUM_LIMITS] = '{
    RTT_W'(10), RTT_W'(50), RTT_W'(100), RTT_W'(200), RTT_W'(500), RTT_W'(1000)
  };

  typedef struct packed {
    logic [RTT_W-1:0] smoothed;
    logic [RTT_W-1:0] variation;
    logic [BKT_W-1:0] bucket;
    logic [CNT_W-1:0] count;
  } update_t;

  function automatic logic [BKT_W-1:0] pick_bucket(input logic [RTT_W-1:0] s);
    logic [BKT_W-1:0] b;
    b = BKT_W'(NUM_LIMITS);
    for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
      if (s < BKT_LIMIT[i]) b = BKT_W'(i);
    end
    return b;
  endfunction

endpackage

@@ src/rre_state.sv @@
// ----------------------------------------------------------------------------
// rre_state
// Estimator state: smoothed RTT, RTT variation and the latency histogram.
// Computes the post-sample values and commits them on each request.
// ----------------------------------------------------------------------------
module rre_state (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [rre_pkg::RTT_W-1:0]  sample,
  output rre_pkg::update_t           upd
);

  logic [rre_pkg::RTT_W-1:0] smoothed;
  logic [rre_pkg::RTT_W-1:0] variation;
  logic [rre_pkg::CNT_W-1:0] histogram [rre_pkg::NUM_BUCKETS];

  logic [rre_pkg::RTT_W-1:0] gap;
  logic [rre_pkg::RTT_W+2:0] var_sum;
  logic [rre_pkg::RTT_W+3:0] smo_sum;
  logic [rre_pkg::BKT_W-1:0] bucket;

  always_comb begin
    bucket  = rre_pkg::pick_bucket(sample);
    gap     = (smoothed > sample) ? (smoothed - sample) : (sample - smoothed);
    var_sum = (rre_pkg::RTT_W+3)'(variation) + (rre_pkg::RTT_W+3)'({variation, 1'b0})
            + (rre_pkg::RTT_W+3)'(gap);
    smo_sum = (rre_pkg::RTT_W+4)'({smoothed, 3'b000}) - (rre_pkg::RTT_W+4)'(smoothed)
            + (rre_pkg::RTT_W+4)'(sample);
    upd.bucket = bucket;
    upd.count  = histogram[bucket] + rre_pkg::CNT_W'(1);
    if (smoothed == '0) begin
      upd.smoothed  = sample;
      upd.variation = {1'b0, sample[rre_pkg::RTT_W-1:1]};
    end else begin
      upd.smoothed  = smo_sum[rre_pkg::RTT_W+2:3];
      upd.variation = var_sum[rre_pkg::RTT_W+1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed  <= '0;
      variation <= '0;
      for (int i = 0; i < rre_pkg::NUM_BUCKETS; i++) histogram[i] <= '0;
    end else if (load) begin
      smoothed          <= upd.smoothed;
      variation         <= upd.variation;
      histogram[bucket] <= upd.count;
    end
  end

endmodule

@@ src/rtt_rto_estimator_top.sv @@
// ----------------------------------------------------------------------------
// rtt_rto_estimator_top
// Jacobson/Karels style RTT smoothing and RTO computation with a
// seven-bucket latency histogram.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | sink      | in_valid / in_stall | rtt_ms
//  out     | source    | out_valid/out_stall | rto_ms smoothed_ms variation_ms
//          |           |                     | bucket_index bucket_count
//  cfg     | sink      | cfg_we              | cfg_index cfg_data
//
//  One request per cycle unless in_stall is high; stages: state update, clamp.
//  Estimator state and histogram commit in the cycle the request is taken.
//  Synchronous reset clears state, histogram and pipeline; clamps go to 200/60000.
//  out_stall holds the output register; in_stall rises only when both stages
//  are full.
// ----------------------------------------------------------------------------
module rtt_rto_estimator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rre_pkg::RTT_W-1:0]      rtt_ms,
  input  logic                           cfg_we,
  input  logic [rre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rre_pkg::RTT_W-1:0]      cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rre_pkg::RTT_W-1:0]      rto_ms,
  output logic [rre_pkg::RTT_W-1:0]      smoothed_ms,
  output logic [rre_pkg::RTT_W-1:0]      variation_ms,
  output logic [rre_pkg::BKT_W-1:0]      bucket_index,
  output logic [rre_pkg::CNT_W-1:0]      bucket_count
);

  logic [rre_pkg::RTT_W-1:0] min_rto;
  logic [rre_pkg::RTT_W-1:0] max_rto;

  logic                 accept;
  logic                 out_free;
  logic                 s1_free;
  logic                 s1_valid;
  rre_pkg::update_t     upd;
  rre_pkg::update_t     s1;

  logic [rre_pkg::VAR4_W-1:0] var4;
  logic [rre_pkg::SUM_W-1:0]  sum;
  logic [rre_pkg::RTT_W-1:0]  rto_next;

  assign out_free = !out_valid || !out_stall;
  assign s1_free  = !s1_valid || out_free;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rto <= rre_pkg::MIN_RTO_RESET;
      max_rto <= rre_pkg::MAX_RTO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rre_pkg::REG_MIN_RTO: min_rto <= cfg_data;
        rre_pkg::REG_MAX_RTO: max_rto <= cfg_data;
        default: ;
      endcase
    end
  end

  rre_state u_state (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .sample (rtt_ms),
    .upd    (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= upd;
    end
  end

  always_comb begin
    var4 = {s1.variation, 2'b00};
    if (var4 < rre_pkg::RTO_FLOOR) var4 = rre_pkg::RTO_FLOOR;
    sum = rre_pkg::SUM_W'(s1.smoothed) + rre_pkg::SUM_W'(var4);
    if (sum < rre_pkg::SUM_W'(min_rto)) begin
      rto_next = min_rto;
    end else if (sum > rre_pkg::SUM_W'(max_rto)) begin
      rto_next = max_rto;
    end else begin
      rto_next = sum[rre_pkg::RTT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_free) begin
      rto_ms       <= rto_next;
      smoothed_ms  <= s1.smoothed;
      variation_ms <= s1.variation;
      bucket_index <= s1.bucket;
      bucket_count <= s1.count;
    end
  end

endmodule

@@ src/rre_checker.sv @@
// ----------------------------------------------------------------------------
// rre_checker
// Port-level checks for the RTT / RTO estimator, bound to the top level.
// ----------------------------------------------------------------------------
module rre_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [rre_pkg::RTT_W-1:0]      rto_ms,
  input logic [rre_pkg::RTT_W-1:0]      smoothed_ms,
  input logic [rre_pkg::RTT_W-1:0]      variation_ms,
  input logic [rre_pkg::BKT_W-1:0]      bucket_index,
  input logic [rre_pkg::CNT_W-1:0]      bucket_count
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled while output can move");

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bucket_index < rre_pkg::BKT_W'(rre_pkg::NUM_BUCKETS))
    else $error("bucket index out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rto_ms) && $stable(smoothed_ms)
      && $stable(variation_ms) && $stable(bucket_index) && $stable(bucket_count))
    else $error("stalled result changed");

endmodule

bind rtt_rto_estimator_top rre_checker u_rre_checker (.*);

@@ bench/tb_rtt_rto_estimator_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtt_rto_estimator_top
// Self-checking bench for the RTT / RTO estimator. Every accepted RTT sample
// is run through an in-bench estimator that tracks smoothed RTT, variation,
// clamp limits and the latency histogram. Each output request is compared
// field by field with the oldest expected update. Covered: seeding and decay,
// bucket edges, clamp extremes with crossed limits, long random traffic under
// varying idle/stall and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_rtt_rto_estimator_top;

  localparam int unsigned PIPE_LATENCY = 2;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RAND_PER_SUB = 180;
  localparam logic [rre_pkg::RTT_W-1:0] RTT_MAX = '1;
  localparam logic [63:0] RTO_FLOOR_MS = 64'd10;
  localparam int unsigned BUCKET_BOUND [6] = '{10, 50, 100, 200, 500, 1000};

  typedef struct packed {
    logic [rre_pkg::RTT_W-1:0] rto;
    logic [rre_pkg::RTT_W-1:0] smoothed;
    logic [rre_pkg::RTT_W-1:0] variation;
    logic [rre_pkg::BKT_W-1:0] bucket;
    logic [rre_pkg::CNT_W-1:0] count;
  } rto_update_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [rre_pkg::RTT_W-1:0]     rtt_ms;
  logic                          cfg_we;
  logic [rre_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rre_pkg::RTT_W-1:0]     cfg_data;
  logic                          out_valid;
  logic                          out_stall;
  logic [rre_pkg::RTT_W-1:0]     rto_ms;
  logic [rre_pkg::RTT_W-1:0]     smoothed_ms;
  logic [rre_pkg::RTT_W-1:0]     variation_ms;
  logic [rre_pkg::BKT_W-1:0]     bucket_index;
  logic [rre_pkg::CNT_W-1:0]     bucket_count;

  // estimator shadow state
  logic [rre_pkg::RTT_W-1:0] est_smoothed;
  logic [rre_pkg::RTT_W-1:0] est_variation;
  logic [rre_pkg::CNT_W-1:0] hist_count [rre_pkg::NUM_BUCKETS];
  logic [rre_pkg::RTT_W-1:0] lim_min;
  logic [rre_pkg::RTT_W-1:0] lim_max;

  rto_update_t pending_updates [$];

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  logic        holding_off;
  event        hold_off_ev;

  int unsigned error_count;
  int unsigned samples_sent;
  int unsigned updates_checked;
  int unsigned cfg_writes;
  int unsigned input_stall_cycles;

  rtt_rto_estimator_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rtt_ms       (rtt_ms),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rto_ms       (rto_ms),
    .smoothed_ms  (smoothed_ms),
    .variation_ms (variation_ms),
    .bucket_index (bucket_index),
    .bucket_count (bucket_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[rtt_rto_estimator_top] ERROR");
    $finish;
  end

  function automatic rto_update_t estimate_rto(input logic [rre_pkg::RTT_W-1:0] s);
    rto_update_t               r;
    logic [rre_pkg::BKT_W-1:0] b;
    logic [rre_pkg::RTT_W-1:0] gap;
    logic [63:0]               var4;
    logic [63:0]               sum;
    b = '0;
    for (int i = 0; i < 6; i++) begin
      if (s >= BUCKET_BOUND[i]) b = rre_pkg::BKT_W'(i + 1);
    end
    hist_count[b] = hist_count[b] + 1'b1;
    if (est_smoothed == '0) begin
      est_smoothed  = s;
      est_variation = s >> 1;
    end else begin
      gap = (est_smoothed > s) ? est_smoothed - s : s - est_smoothed;
      est_variation = rre_pkg::RTT_W'((64'(est_variation) * 3 + 64'(gap)) >> 2);
      est_smoothed  = rre_pkg::RTT_W'((64'(est_smoothed) * 7 + 64'(s)) >> 3);
    end
    var4 = 64'(est_variation) << 2;
    if (var4 < RTO_FLOOR_MS) var4 = RTO_FLOOR_MS;
    sum = 64'(est_smoothed) + var4;
    if (sum < 64'(lim_min)) r.rto = lim_min;
    else if (sum > 64'(lim_max)) r.rto = lim_max;
    else r.rto = rre_pkg::RTT_W'(sum);
    r.smoothed  = est_smoothed;
    r.variation = est_variation;
    r.bucket    = b;
    r.count     = hist_count[b];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // output side: random stall plus the long hold-off window
  always @(negedge clk) begin
    out_stall = holding_off || ($urandom_range(99) < stall_pct);
  end

  initial begin
    holding_off = 1'b0;
    forever begin
      @(hold_off_ev);
      holding_off = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      holding_off = 1'b0;
    end
  end

  always @(posedge clk) begin
    rto_update_t want;
    if (!rst) begin
      if (in_valid && in_stall) input_stall_cycles++;
      if (out_valid && !out_stall) begin
        if (pending_updates.size() == 0) begin
          report_mismatch("update with none pending, rto", 64'(rto_ms), 64'd0);
        end else begin
          want = pending_updates.pop_front();
          updates_checked++;
          if (rto_ms !== want.rto)
            report_mismatch("rto_ms", 64'(rto_ms), 64'(want.rto));
          if (smoothed_ms !== want.smoothed)
            report_mismatch("smoothed_ms", 64'(smoothed_ms), 64'(want.smoothed));
          if (variation_ms !== want.variation)
            report_mismatch("variation_ms", 64'(variation_ms), 64'(want.variation));
          if (bucket_index !== want.bucket)
            report_mismatch("bucket_index", 64'(bucket_index), 64'(want.bucket));
          if (bucket_count !== want.count)
            report_mismatch("bucket_count", 64'(bucket_count), 64'(want.count));
        end
      end
    end
  end

  task automatic send_sample(input logic [rre_pkg::RTT_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rtt_ms   = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_updates.insert(pending_updates.size(), estimate_rto(v));
    samples_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rre_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rre_pkg::RTT_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == rre_pkg::REG_MIN_RTO) lim_min = val;
    else lim_max = val;
    cfg_writes++;
  endtask

  task automatic set_clamps(input logic [rre_pkg::RTT_W-1:0] lo,
                            input logic [rre_pkg::RTT_W-1:0] hi);
    wait_idle();
    write_reg(rre_pkg::REG_MIN_RTO, lo);
    write_reg(rre_pkg::REG_MAX_RTO, hi);
  endtask

  function automatic logic [rre_pkg::RTT_W-1:0] next_rtt_sample();
    int unsigned k;
    int          t;
    k = $urandom_range(99);
    if (k < 35) return rre_pkg::RTT_W'($urandom_range(1200));
    if (k < 55) return rre_pkg::RTT_W'($urandom);
    if (k < 70) begin
      t = int'(est_smoothed) + int'($urandom_range(64)) - 32;
      if (t < 0) t = 0;
      if (t > int'(RTT_MAX)) t = int'(RTT_MAX);
      return rre_pkg::RTT_W'(t);
    end
    if (k < 80) begin
      t = int'(BUCKET_BOUND[$urandom_range(5)]) - int'($urandom_range(1));
      return rre_pkg::RTT_W'(t);
    end
    if (k < 85) return ($urandom_range(1) == 0) ? '0 : RTT_MAX;
    if (k < 92) return rre_pkg::RTT_W'($urandom_range(3));
    return rre_pkg::RTT_W'($urandom_range(20000));
  endfunction

  task automatic test_seed_and_decay();
    send_sample('0);
    send_sample('0);
    send_sample(rre_pkg::RTT_W'(1));
    send_sample('0);
    send_sample(rre_pkg::RTT_W'(9));
  endtask

  task automatic test_bucket_edges();
    int unsigned edges [12] = '{10, 49, 50, 99, 100, 199, 200, 499, 500, 999, 1000, 1048575};
    foreach (edges[i]) send_sample(rre_pkg::RTT_W'(edges[i]));
  endtask

  task automatic test_clamp_extremes();
    set_clamps('0, RTT_MAX);
    send_sample(RTT_MAX);
    send_sample('0);
    set_clamps(RTT_MAX, '0);
    send_sample(rre_pkg::RTT_W'(300));
    send_sample(RTT_MAX);
    set_clamps(rre_pkg::RTT_W'(5000), rre_pkg::RTT_W'(100));
    send_sample(rre_pkg::RTT_W'(3));
    send_sample(rre_pkg::RTT_W'(70000));
    set_clamps('0, '0);
    send_sample(rre_pkg::RTT_W'(1));
  endtask

  task automatic test_random_traffic(input int unsigned per_sub);
    int unsigned send_tab  [4] = '{0, 46, 0, 21};
    int unsigned stall_tab [4] = '{0, 0, 46, 21};
    int unsigned sent;
    int unsigned run;
    int unsigned span;
    logic [rre_pkg::RTT_W-1:0] lo;
    logic [rre_pkg::RTT_W-1:0] hi;
    for (int m = 0; m < 4; m++) begin
      for (int sub = 0; sub < 2; sub++) begin
        if ($urandom_range(3) == 0) begin
          lo = rre_pkg::RTT_W'($urandom);
          hi = rre_pkg::RTT_W'($urandom);
        end else begin
          lo   = rre_pkg::RTT_W'($urandom_range(2000));
          span = $urandom_range(100000);
          hi = (64'(lo) + 64'(span) > 64'(RTT_MAX)) ? RTT_MAX :
               rre_pkg::RTT_W'(64'(lo) + 64'(span));
        end
        set_clamps(lo, hi);
        send_idle_pct = send_tab[m];
        stall_pct     = stall_tab[m];
        sent = 0;
        while (sent < per_sub) begin
          if ($urandom_range(99) < 3) begin
            // small seed followed by zeros: smoothed decays toward zero and may reach it and reseed
            run = $urandom_range(30, 1);
            send_sample(rre_pkg::RTT_W'($urandom_range(7, 1)));
            repeat (run) send_sample('0);
            sent += run + 1;
          end else begin
            send_sample(next_rtt_sample());
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_output_holdoff();
    wait_idle();
    send_idle_pct = 0;
    stall_pct     = 10;
    -> hold_off_ev;
    repeat (60) send_sample(next_rtt_sample());
    wait_idle();
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    rtt_ms        = '0;
    cfg_we        = 1'b0;
    cfg_index     = rre_pkg::REG_MIN_RTO;
    cfg_data      = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    error_count   = 0;
    samples_sent  = 0;
    updates_checked    = 0;
    cfg_writes         = 0;
    input_stall_cycles = 0;
    est_smoothed  = '0;
    est_variation = '0;
    lim_min       = rre_pkg::MIN_RTO_RESET;
    lim_max       = rre_pkg::MAX_RTO_RESET;
    foreach (hist_count[i]) hist_count[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_seed_and_decay();
    test_bucket_edges();
    test_clamp_extremes();
    test_random_traffic(RAND_PER_SUB);
    test_output_holdoff();

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_updates.size() != 0)
      report_mismatch("updates never delivered", 64'(pending_updates.size()), 64'd0);
    $display("Run: %0d samples, %0d updates checked, %0d clamp register writes",
             samples_sent, updates_checked, cfg_writes);
    $display("Input held off in %0d cycles; %0d mismatches", input_stall_cycles,
             error_count);
    if (error_count == 0) begin
      $display("[rtt_rto_estimator_top] OK");
    end else begin
      $display("[rtt_rto_estimator_top] ERROR");
    end
    $finish;
  end

endmodule
